// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the shell sort engine modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define SSORT_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("ssort assertion failed");

// Antecedent implies consequent in the same cycle.
`define SSORT_ASSERT_IMPLY(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("ssort assertion failed");

// Antecedent implies consequent in the next cycle.
`define SSORT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ssort assertion failed");

`endif

// ===== rtl/ssort_pkg.sv =====
// ----------------------------------------------------------------------------
// ssort_pkg
// Sizes, microcode encodings and the control program of the shell sort engine.
// ----------------------------------------------------------------------------
package ssort_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    // Program steps
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_GAP_INIT,
        ST_I_INIT,
        ST_FETCH_I,
        ST_HOLD,
        ST_READ_JG,
        ST_CMP,
        ST_PLACE,
        ST_HALVE,
        ST_EMIT_INIT,
        ST_EMIT_READ,
        ST_EMIT_PUSH,
        ST_CLEAR
    } step_t;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_GAP_INIT,
        OP_I_INIT,
        OP_FETCH_I,
        OP_HOLD,
        OP_READ_JG,
        OP_SHIFT,
        OP_PLACE,
        OP_HALVE,
        OP_EMIT_INIT,
        OP_READ_K,
        OP_PUSH,
        OP_CLEAR
    } dp_op_t;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_LAST,
        C_GAP_ZERO,
        C_I_GE_N,
        C_J_LT_GAP,
        C_GT,
        C_OUT_BUSY,
        C_MORE
    } cond_t;

    typedef struct packed {
        dp_op_t op;
        cond_t  cond;
        step_t  target;
    } uword_t;

    // Flags the sequencer tests
    typedef struct packed {
        logic last_beat;
        logic gap_zero;
        logic i_ge_n;
        logic j_lt_gap;
        logic gt;
        logic out_busy;
        logic more;
    } flags_t;

    // Datapath status towards the sequencer
    typedef struct packed {
        logic gap_zero;
        logic i_ge_n;
        logic j_lt_gap;
        logic gt;
        logic more;
    } dp_status_t;

    // One result beat from the datapath
    typedef struct packed {
        logic              push;
        logic [DATA_W-1:0] value;
        logic              last;
    } emit_t;

    // Control store: one word per step
    function automatic uword_t ucode_rom(step_t addr);
        uword_t w;
        unique case (addr)
            ST_LOAD:      w = '{OP_LOAD,      C_NO_LAST,  ST_LOAD};
            ST_GAP_INIT:  w = '{OP_GAP_INIT,  C_NEVER,    ST_LOAD};
            ST_I_INIT:    w = '{OP_I_INIT,    C_GAP_ZERO, ST_EMIT_INIT};
            ST_FETCH_I:   w = '{OP_FETCH_I,   C_I_GE_N,   ST_HALVE};
            ST_HOLD:      w = '{OP_HOLD,      C_NEVER,    ST_LOAD};
            ST_READ_JG:   w = '{OP_READ_JG,   C_J_LT_GAP, ST_PLACE};
            ST_CMP:       w = '{OP_SHIFT,     C_GT,       ST_READ_JG};
            ST_PLACE:     w = '{OP_PLACE,     C_ALWAYS,   ST_FETCH_I};
            ST_HALVE:     w = '{OP_HALVE,     C_ALWAYS,   ST_I_INIT};
            ST_EMIT_INIT: w = '{OP_EMIT_INIT, C_NEVER,    ST_LOAD};
            ST_EMIT_READ: w = '{OP_READ_K,    C_OUT_BUSY, ST_EMIT_READ};
            ST_EMIT_PUSH: w = '{OP_PUSH,      C_MORE,     ST_EMIT_READ};
            ST_CLEAR:     w = '{OP_CLEAR,     C_ALWAYS,   ST_LOAD};
            default:      w = '{OP_NOP,       C_ALWAYS,   ST_LOAD};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/ssort_seq.sv =====
// ----------------------------------------------------------------------------
// ssort_seq
// Step counter and control store: fetches one word per cycle, evaluates its
// jump condition and issues the datapath operation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssort_seq
    import ssort_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  flags_t flags,
    output dp_op_t op
);

    step_t  step_reg;
    step_t  step_next;
    uword_t word;
    logic   take;

    assign word = ucode_rom(step_reg);

    always_comb
    begin
        unique case (word.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_LAST:  take = !flags.last_beat;
            C_GAP_ZERO: take = flags.gap_zero;
            C_I_GE_N:   take = flags.i_ge_n;
            C_J_LT_GAP: take = flags.j_lt_gap;
            C_GT:       take = flags.gt;
            C_OUT_BUSY: take = flags.out_busy;
            C_MORE:     take = flags.more;
            default:    take = 1'b1;
        endcase
    end

    always_comb
    begin
        if (take)
        begin
            step_next = word.target;
        end
        else
        begin
            step_next = step_t'(step_reg + 4'd1);
        end
    end

    always_comb
    begin
        op = word.op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_LOAD;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    `SSORT_ASSERT_NEXT(a_clear_returns_to_load, clk, rst_n, step_reg == ST_CLEAR, step_reg == ST_LOAD)
    `SSORT_ASSERT_IMPLY(a_busy_holds_emit, clk, rst_n, (step_reg == ST_EMIT_READ) && flags.out_busy, step_next == ST_EMIT_READ)

endmodule

// ===== rtl/ssort_dp.sv =====
// ----------------------------------------------------------------------------
// ssort_dp
// Element store, index registers and compare logic, driven one operation per
// cycle by the sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssort_dp
    import ssort_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dp_op_t            op,
    input  logic              in_valid,
    input  logic [DATA_W-1:0] element,
    output dp_status_t        status,
    output emit_t             emit
);

    logic [DATA_W-1:0] mem [MAX_ITEMS];

    logic [CNT_W-1:0]  n_reg,   n_next;
    logic [CNT_W-1:0]  i_reg,   i_next;
    logic [ADDR_W-1:0] j_reg,   j_next;
    logic [ADDR_W-1:0] gap_reg, gap_next;
    logic [DATA_W-1:0] held_reg, held_next;
    logic [DATA_W-1:0] rdata_reg;

    logic              wr_en;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] j_back;
    logic [CNT_W-1:0]  i_inc;
    logic              gt;

    assign j_back = j_reg - gap_reg;
    assign i_inc  = i_reg + CNT_W'(1);
    assign gt     = $signed(rdata_reg) > $signed(held_reg);

    always_comb
    begin
        n_next    = n_reg;
        i_next    = i_reg;
        j_next    = j_reg;
        gap_next  = gap_reg;
        held_next = held_reg;
        wr_en     = 1'b0;
        waddr     = j_reg;
        wdata     = rdata_reg;
        raddr     = i_reg[ADDR_W-1:0];
        unique case (op)
            OP_LOAD:
            begin
                // drop the beat when the store is full
                if (in_valid && (n_reg < CNT_W'(MAX_ITEMS)))
                begin
                    wr_en  = 1'b1;
                    waddr  = n_reg[ADDR_W-1:0];
                    wdata  = element;
                    n_next = n_reg + CNT_W'(1);
                end
            end
            OP_GAP_INIT:  gap_next = ADDR_W'(n_reg >> 1);
            OP_I_INIT:    i_next   = CNT_W'(gap_reg);
            OP_FETCH_I:   j_next   = i_reg[ADDR_W-1:0];
            OP_HOLD:      held_next = rdata_reg;
            OP_READ_JG:   raddr    = j_back;
            OP_SHIFT:
            begin
                if (gt)
                begin
                    wr_en  = 1'b1;
                    wdata  = rdata_reg;
                    j_next = j_back;
                end
            end
            OP_PLACE:
            begin
                wr_en  = 1'b1;
                wdata  = held_reg;
                i_next = i_inc;
            end
            OP_HALVE:     gap_next = gap_reg >> 1;
            OP_EMIT_INIT: i_next   = '0;
            OP_READ_K:    raddr    = i_reg[ADDR_W-1:0];
            OP_PUSH:      i_next   = i_inc;
            OP_CLEAR:     n_next   = '0;
            OP_NOP:       n_next   = n_reg;
            default:      n_next   = n_reg;
        endcase
    end

    always_comb
    begin
        status.gap_zero = (gap_reg == '0);
        status.i_ge_n   = (i_reg >= n_reg);
        status.j_lt_gap = (j_reg < gap_reg);
        status.gt       = gt;
        status.more     = (i_inc < n_reg);
        emit.push       = (op == OP_PUSH);
        emit.value      = rdata_reg;
        emit.last       = (i_inc == n_reg);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
        held_reg  <= held_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg   <= '0;
            i_reg   <= '0;
            j_reg   <= '0;
            gap_reg <= '0;
        end
        else
        begin
            n_reg   <= n_next;
            i_reg   <= i_next;
            j_reg   <= j_next;
            gap_reg <= gap_next;
        end
    end

    `SSORT_ASSERT_ALWAYS(a_count_bound, clk, rst_n, n_reg <= CNT_W'(MAX_ITEMS))
    `SSORT_ASSERT_IMPLY(a_j_within_i, clk, rst_n, op == OP_READ_JG, {1'b0, j_reg} <= i_reg)
    `SSORT_ASSERT_NEXT(a_shift_steps_back, clk, rst_n, (op == OP_SHIFT) && gt, j_reg == $past(j_back))

endmodule

// ===== rtl/shell_sort_engine.sv =====
// ----------------------------------------------------------------------------
// shell_sort_engine
// Collects up to MAX_ITEMS signed 32-bit elements, sorts them ascending by
// Shell sort (gaps n/2 down to 1) and streams the sorted set back out.
//
// Input channel (in_valid / in_stall, element, is_last): one element per
// beat while loading; the beat with is_last closes the set. Beats beyond
// MAX_ITEMS are dropped, though a dropped is_last still closes the set.
// in_stall rises after the closing beat and stays high through sorting,
// emission and the clear step that follows the last output push.
// Output channel (out_valid / out_stall, sorted_value, end_of_set): one beat
// per element in ascending order, end_of_set on the final one. Results come
// from an output register; out_stall holds it and the sequencer waits.
// Sorting uses one read and one write port on the store. Each gap pass
// starts i at the gap; each insertion fetches and holds element i, then
// shifts the elements one gap back up while they exceed the held value
// and the chain front is not reached, then places the held value there.
// Emission reads and pushes each element, then the set is cleared.
// Reset empties the set and returns the sequencer to loading.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module shell_sort_engine
    import ssort_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [DATA_W-1:0] element,
    input  logic              is_last,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] sorted_value,
    output logic              end_of_set
);

    dp_op_t            op;
    dp_status_t        status;
    emit_t             emit;
    flags_t            flags;

    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] sorted_value_reg;
    logic              end_of_set_reg;

    assign in_stall = (op != OP_LOAD);

    always_comb
    begin
        flags.last_beat = in_valid && is_last && !in_stall;
        flags.gap_zero  = status.gap_zero;
        flags.i_ge_n    = status.i_ge_n;
        flags.j_lt_gap  = status.j_lt_gap;
        flags.gt        = status.gt;
        flags.out_busy  = out_valid_reg && out_stall;
        flags.more      = status.more;
    end

    ssort_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .op    (op)
    );

    ssort_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .in_valid (in_valid),
        .element  (element),
        .status   (status),
        .emit     (emit)
    );

    // Output register: load on push, clear once the beat is taken
    always_comb
    begin
        if (emit.push)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.push)
        begin
            sorted_value_reg <= emit.value;
            end_of_set_reg   <= emit.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sorted_value = sorted_value_reg;
    assign end_of_set   = end_of_set_reg;

    `SSORT_ASSERT_IMPLY(a_push_into_free_slot, clk, rst_n, emit.push, !(out_valid_reg && out_stall))

endmodule
